FILE: hw/rtl/suie_pkg.sv
// shared types and constants for the set union / intersection engine
// beat structs, request codes and cell control; no dependencies
package suie_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam logic [1:0] REQ_ELEM_A = 2'd0;
  localparam logic [1:0] REQ_ELEM_B = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] elem_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_valid;
    logic               out_last;
    logic               overflowed;
  } out_beat_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e    op;
    logic [31:0] value;
    logic        is_b;
  } cell_ctrl_t;

  typedef struct packed {
    logic        valid;
    logic        seen_a;
    logic        seen_b;
    logic [31:0] value;
  } entry_t;

endpackage

FILE: hw/rtl/suie_cell.sv
// one table entry of the cell chain: value, list marks and a compare
// depends on suie_pkg
module suie_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  suie_pkg::cell_ctrl_t ctrl_i,
  input  logic                any_hit_i,
  input  logic                prev_valid_i,
  input  suie_pkg::entry_t    next_ent_i,
  output suie_pkg::entry_t    ent_o,
  output logic                hit_o
);
  import suie_pkg::*;

  logic        valid_q;
  logic        seen_a_q;
  logic        seen_b_q;
  logic [31:0] value_q;
  logic        take_slot;

  assign hit_o     = valid_q && (value_q == ctrl_i.value);
  // first free cell behind the filled run takes a new value
  assign take_slot = !valid_q && prev_valid_i && !any_hit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      seen_a_q <= 1'b0;
      seen_b_q <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        CELL_HOLD: begin
        end
        CELL_INSERT: begin
          if (hit_o) begin
            if (ctrl_i.is_b) seen_b_q <= 1'b1;
            else             seen_a_q <= 1'b1;
          end else if (take_slot) begin
            valid_q  <= 1'b1;
            seen_a_q <= !ctrl_i.is_b;
            seen_b_q <= ctrl_i.is_b;
          end
        end
        CELL_SHIFT: begin
          valid_q  <= next_ent_i.valid;
          seen_a_q <= next_ent_i.seen_a;
          seen_b_q <= next_ent_i.seen_b;
        end
        CELL_CLEAR: begin
          valid_q  <= 1'b0;
          seen_a_q <= 1'b0;
          seen_b_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == CELL_INSERT && take_slot) value_q <= ctrl_i.value;
    else if (ctrl_i.op == CELL_SHIFT)          value_q <= next_ent_i.value;
  end

  assign ent_o = '{valid: valid_q, seen_a: seen_a_q, seen_b: seen_b_q, value: value_q};

endmodule

FILE: hw/rtl/set_union_intersection_engine_unit.sv
// top level of the set union / intersection engine: a chain of table cells
// with broadcast compare and a head-of-chain emitter; depends on suie_pkg, suie_cell
//
// element beats (list a or b) leave busy low; while idle, one per cycle is taken
// finish beat: busy rises while the chain shifts toward cell 0 one entry a cycle;
// each result shows in the cycle after its emit cycle
// results carry no back pressure: the strobe lasts exactly one cycle
// reset clears all entry marks, the overflow flag and op_mode (union)
module set_union_intersection_engine_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  suie_pkg::in_beat_t  req_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  output logic                res_valid_o,
  output suie_pkg::out_beat_t res_o
);
  import suie_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic       op_mode_q;
  logic       ovf_q;
  logic       res_valid_q;
  out_beat_t  res_q;

  entry_t               ent [CAPACITY];
  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY-1:0]  qual;
  cell_ctrl_t           ctrl;

  logic is_elem;
  logic any_hit;
  logic rest_any;
  logic emit_take;
  logic emit_none;
  logic emit_end;

  // element beat accepted this cycle
  assign is_elem = start && !busy &&
                   (req_i.req_type == REQ_ELEM_A || req_i.req_type == REQ_ELEM_B);
  assign any_hit = |hit;

  // cell command: insert an element beat when idle, shift during emit, clear on the final emit
  always_comb begin
    ctrl.value   = req_i.elem_value;
    ctrl.is_b    = (req_i.req_type == REQ_ELEM_B);
    if (busy) begin
      ctrl.op = emit_end ? CELL_CLEAR : CELL_SHIFT;
    end else if (is_elem) begin
      ctrl.op = CELL_INSERT;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  // the cell chain; cell i shifts in the entry of cell i+1
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   prev_valid;
    entry_t next_ent;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = ent[i-1].valid;
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_link
      assign next_ent = ent[i+1];
    end

    suie_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .any_hit_i    (any_hit),
      .prev_valid_i (prev_valid),
      .next_ent_i   (next_ent),
      .ent_o        (ent[i]),
      .hit_o        (hit[i])
    );

    // entry belongs to the result set in the current mode
    assign qual[i] = ent[i].valid && (!op_mode_q || (ent[i].seen_a && ent[i].seen_b));
  end

  // head-of-chain decisions during emit
  assign rest_any  = |qual[CAPACITY-1:1];
  assign emit_take = qual[0];
  assign emit_none = !(|qual);
  assign emit_end  = emit_none || (emit_take && !rest_any);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      op_mode_q <= cfg_wdata_i;
    end
  end

  // state, overflow flag and the registered result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          // new distinct value with the whole chain full is dropped
          if (is_elem && !any_hit && ent[CAPACITY-1].valid) begin
            ovf_q <= 1'b1;
          end
          if (start && req_i.req_type == REQ_FINISH) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_take || emit_none) begin
            res_valid_q      <= 1'b1;
            res_q.out_value  <= emit_take ? signed'(ent[0].value) : '0;
            res_q.out_valid  <= emit_take;
            res_q.out_last   <= emit_end;
            res_q.overflowed <= ovf_q;
          end
          if (emit_end) begin
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q == ST_EMIT);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // emit only ever starts from an accepted finish beat
  a_busy_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && req_i.req_type == REQ_FINISH))
    else $error("emit started without a finish beat");

  // every result beat comes out of an emit cycle
  a_res_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result beat outside emit");

  // the final result closes the emit phase
  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.out_last) |-> !busy)
    else $error("emit still running after last result");

  // an empty result is always the only and final one
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.out_valid) |-> (res_o.out_last && res_o.out_value == '0))
    else $error("empty result not marked last");

  // the table is clear once emit finishes
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (!ent[0].valid && !ovf_q))
    else $error("table not cleared after emit");

endmodule

FILE: verif/set_union_intersection_engine_unit_tb.sv
// self-checking testbench for set_union_intersection_engine_unit: directed script, then
// random list a / list b runs closed by finish beats; depends on suie_pkg and the rtl
module set_union_intersection_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import suie_pkg::*;

  // spurious results could trail a finish by up to a full table emit
  localparam int unsigned DRAIN_WAIT   = CAPACITY + 4;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned RANDOM_BEATS = 300;
  // random beats in this window are sent back to back
  localparam int unsigned CALM_FROM    = 120;
  localparam int unsigned CALM_TO      = 200;

  // request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic       MODE_UNION = 1'b0;
  localparam logic       MODE_ISECT = 1'b1;

  localparam out_beat_t EMPTY_SET = '{32'sd0, 1'b0, 1'b1, 1'b0};
  localparam out_beat_t NO_WANT   = '0;

  typedef enum logic {ROW_BEAT, ROW_MODE} row_kind_e;

  // one line of the directed script; a mode row carries the mode in value[0]
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  req;
    logic [31:0] value;
    logic        chk;
    out_beat_t   want;
  } script_row_t;

  localparam int unsigned SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // finish right after reset: one empty result
    '{ROW_BEAT, REQ_FINISH, 32'h0000_0000, 1'b1, EMPTY_SET},
    // extremes of both lists, repeats and cross marks
    '{ROW_BEAT, REQ_ELEM_A, 32'h7fff_ffff, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_A, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_B, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_B, 32'hffff_ffff, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_A, 32'h7fff_ffff, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_B, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_A, 32'h0000_0000, 1'b0, NO_WANT},
    // union of the above in first-appearance order
    '{ROW_BEAT, REQ_FINISH, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_MODE, REQ_ELEM_A, {31'd0, MODE_ISECT}, 1'b0, NO_WANT},
    // disjoint lists intersect to nothing
    '{ROW_BEAT, REQ_ELEM_A, 32'h0000_0005, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_B, 32'h0000_0006, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_FINISH, 32'h0000_0000, 1'b1, EMPTY_SET},
    // b before a still intersects; alternating bit patterns stay one-sided
    '{ROW_BEAT, REQ_ELEM_B, 32'h0000_0007, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_A, 32'h0000_0007, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_A, 32'h5555_5555, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_ELEM_B, 32'haaaa_aaaa, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_FINISH, 32'h0000_0000, 1'b1, '{32'sd7, 1'b1, 1'b1, 1'b0}},
    // unused request code leaves the table alone; finish value is don't care
    '{ROW_BEAT, REQ_UNUSED, 32'h0000_0009, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_FINISH, 32'hdead_beef, 1'b1, EMPTY_SET},
    '{ROW_MODE, REQ_ELEM_A, {31'd0, MODE_UNION}, 1'b0, NO_WANT},
    // a b-only value still shows up in union mode
    '{ROW_BEAT, REQ_ELEM_B, 32'hffff_fffb, 1'b0, NO_WANT},
    '{ROW_BEAT, REQ_FINISH, 32'h0000_0000, 1'b1, '{-32'sd5, 1'b1, 1'b1, 1'b0}}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      start       = 1'b0;
  logic      busy;
  in_beat_t  req_i       = '0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      res_valid_o;
  out_beat_t res_o;

  set_union_intersection_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // mirror of the distinct-value table, kept in first-appearance order
  logic [31:0] tbl_value [CAPACITY];
  bit          tbl_in_a  [CAPACITY];
  bit          tbl_in_b  [CAPACITY];
  int unsigned tbl_count   = 0;
  bit          tbl_dropped = 1'b0;
  bit          isect_mode  = MODE_UNION;

  out_beat_t   set_members[$];      // results caused by the latest beat
  out_beat_t   pending_members[$];  // results still owed by the block
  int unsigned error_count = 0;
  int unsigned beats_sent  = 0;
  bit          gaps_on     = 1'b1;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // insert or mark an element, or emit and clear the table on finish
  function automatic void step_table(input in_beat_t b);
    int unsigned hit;
    bit          found;
    out_beat_t   r;
    set_members.delete();
    if (b.req_type == REQ_ELEM_A || b.req_type == REQ_ELEM_B) begin
      found = 1'b0;
      hit   = 0;
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (!found && tbl_value[i] == b.elem_value) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (found) begin
        if (b.req_type == REQ_ELEM_B) tbl_in_b[hit] = 1'b1;
        else tbl_in_a[hit] = 1'b1;
      end else if (tbl_count < CAPACITY) begin
        tbl_value[tbl_count] = b.elem_value;
        tbl_in_a[tbl_count]  = (b.req_type == REQ_ELEM_A);
        tbl_in_b[tbl_count]  = (b.req_type == REQ_ELEM_B);
        tbl_count++;
      end else begin
        // table full: the new value is lost
        tbl_dropped = 1'b1;
      end
    end else if (b.req_type == REQ_FINISH) begin
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (isect_mode == MODE_UNION || (tbl_in_a[i] && tbl_in_b[i])) begin
          r.out_value  = tbl_value[i];
          r.out_valid  = 1'b1;
          r.out_last   = 1'b0;
          r.overflowed = tbl_dropped;
          set_members.push_back(r);
        end
      end
      if (set_members.size() == 0) begin
        r = EMPTY_SET;
        r.overflowed = tbl_dropped;
      end else begin
        r = set_members.pop_back();
        r.out_last = 1'b1;
      end
      set_members.push_back(r);
      // table, marks and overflow go back to empty; the mode stays
      for (int unsigned i = 0; i < CAPACITY; i++) begin
        tbl_in_a[i] = 1'b0;
        tbl_in_b[i] = 1'b0;
      end
      tbl_count   = 0;
      tbl_dropped = 1'b0;
    end
  endfunction

  // present one beat, wait for the block to take it, then book its results;
  // a typed-in result replaces the predicted one where the script has it
  task automatic send_beat(input in_beat_t b, input bit chk, input out_beat_t want);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= b;
    do @(posedge clk_i); while (busy);
    step_table(b);
    if (chk) pending_members.push_back(want);
    else foreach (set_members[k]) pending_members.push_back(set_members[k]);
    beats_sent++;
  endtask

  // stop sending until every owed result has shown up
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_members.size() != 0);
  endtask

  // mode change only on an idle block; element beats owe no results, so let
  // the last one settle before the write
  task automatic write_mode(input bit m);
    hold_until_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    isect_mode = m;
    cfg_we_i <= 1'b0;
  endtask

  // every result beat must match the oldest owed one, field by field
  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_members.size() == 0) begin
        $error("unexpected result beat: out_value %0d", res_o.out_value);
        error_count++;
      end else begin
        want = pending_members.pop_front();
        if (res_o.out_value !== want.out_value) begin
          $error("out_value: expected %0d, got %0d", want.out_value, res_o.out_value);
          error_count++;
        end
        if (res_o.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0b, got %0b", want.out_valid, res_o.out_valid);
          error_count++;
        end
        if (res_o.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, res_o.out_last);
          error_count++;
        end
        if (res_o.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, res_o.overflowed);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    in_beat_t    b;
    script_row_t row;
    bit          fill;
    int unsigned len;
    int unsigned seq_no;
    int unsigned first_rand;
    int unsigned pick;
    logic [31:0] v;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row = SCRIPT[i];
      if (row.kind == ROW_MODE) begin
        write_mode(row.value[0]);
      end else begin
        b.req_type   = row.req;
        b.elem_value = row.value;
        send_beat(b, row.chk, row.want);
      end
    end

    // random runs: mostly short lists, partly from a small pool and the extremes so
    // repeats and cross marks are common, now and then a run past the table size
    first_rand = beats_sent;
    seq_no     = 0;
    while (beats_sent - first_rand < RANDOM_BEATS) begin
      // second run goes past the table size in intersection mode, mostly ending empty
      if (seq_no == 1) write_mode(MODE_ISECT);
      else if ($urandom_range(4) == 0) write_mode(1'($urandom_range(1)));

      fill = (seq_no < 2) || ($urandom_range(11) == 0);
      len  = fill ? CAPACITY + $urandom_range(1, 8) : $urandom_range(0, 12);
      for (int unsigned j = 0; j < len; j++) begin
        // occasional unused code as noise
        if ($urandom_range(19) == 0) b.req_type = REQ_UNUSED;
        else b.req_type = $urandom_range(1) ? REQ_ELEM_B : REQ_ELEM_A;
        pick = fill ? 3 : $urandom_range(3);
        case (pick)
          0: v = $urandom_range(7);
          1: v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
          default: v = $urandom;
        endcase
        b.elem_value = v;
        gaps_on = (beats_sent - first_rand < CALM_FROM) ||
                  (beats_sent - first_rand >= CALM_TO);
        send_beat(b, 1'b0, NO_WANT);
      end
      b.req_type   = REQ_FINISH;
      b.elem_value = $urandom;
      send_beat(b, 1'b0, NO_WANT);
      if ($urandom_range(3) == 0) hold_until_drained();
      seq_no++;
    end

    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0 && pending_members.size() == 0) begin
      $display("set_union_intersection_engine_unit_tb OK");
    end else begin
      $display("set_union_intersection_engine_unit_tb NOT OK");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("set_union_intersection_engine_unit_tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/suie_pkg.sv
hw/rtl/suie_cell.sv
hw/rtl/set_union_intersection_engine_unit.sv
verif/set_union_intersection_engine_unit_tb.sv
